@@ rtl/acs_pkg.sv @@
package acs_pkg;

    // Request codes
    localparam logic [1:0] ACT_PLAY    = 2'd0;
    localparam logic [1:0] ACT_ENQUEUE = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;
    localparam logic [1:0] ACT_DEFINE  = 2'd3;

    // One clip table entry: frame range and default speed (Q7.8)
    typedef struct packed {
        logic [15:0]        first_frame;
        logic [15:0]        last_frame;
        logic signed [15:0] def_speed;
    } clip_t;

    // One pending queue entry, with a copy of its clip's frame range
    typedef struct packed {
        logic [4:0]         index;
        logic               loop;
        logic signed [15:0] speed;
        logic [15:0]        first_frame;
        logic [15:0]        last_frame;
    } entry_t;

    // Request held in the input register
    typedef struct packed {
        logic [1:0]         action;
        logic [4:0]         index;      // index for play and enqueue, mapped to 0 when out of range
        logic [4:0]         raw_index;  // index as given, for define
        logic               def_ok;     // define index within the table
        logic               loop;
        logic signed [15:0] speed;
        logic [15:0]        step;
        clip_t              def_clip;
    } item_t;

    // Queue control from the player
    typedef struct packed {
        logic   push;
        logic   pop;
        logic   flush;
        entry_t entry;
    } q_ctl_t;

    // Table update, seen by every copy of a clip's range
    typedef struct packed {
        logic       en;
        logic [4:0] index;
        clip_t      clip;
    } def_upd_t;

    // Time at which a clip starts: end frame when running backwards
    function automatic logic signed [31:0] start_time(
        input logic [15:0]        first_frame,
        input logic [15:0]        last_frame,
        input logic signed [15:0] spd
    );
        logic signed [31:0] t;
        if (spd < 0)
        begin
            t = $signed({8'd0, last_frame, 8'd0});
        end
        else
        begin
            t = $signed({8'd0, first_frame, 8'd0});
        end
        return t;
    endfunction

    // Saturate a widened time to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -34'sh0_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/acs_ram.sv @@
module acs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/acs_clip_table.sv @@
module acs_clip_table #(
    parameter int CLIP_SLOTS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [4:0]       rd_index,
    input  acs_pkg::def_upd_t wr,
    output acs_pkg::clip_t   rd_clip
);

    localparam int AW = $clog2(CLIP_SLOTS);
    localparam int WW = AW + 5;
    localparam int CW = $bits(acs_pkg::clip_t);

    logic [WW-1:0]         rd_wide;
    logic [WW-1:0]         wr_wide;
    logic [AW-1:0]         rd_a;
    logic [AW-1:0]         wr_a;
    logic [CW-1:0]         ram_q;
    logic [CLIP_SLOTS-1:0] written_reg;
    logic                  written_q_reg;
    logic                  byp_hit_reg;
    acs_pkg::clip_t        byp_clip_reg;

    assign rd_wide = WW'(rd_index);
    assign wr_wide = WW'(wr.index);
    assign rd_a    = rd_wide[AW-1:0];
    assign wr_a    = wr_wide[AW-1:0];

    acs_ram #(
        .WIDTH (CW),
        .DEPTH (CLIP_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr_a),
        .wr_data (wr.clip),
        .rd_en   (rd_en),
        .rd_addr (rd_a),
        .rd_data (ram_q)
    );

    // Track written entries; forward a write that lands on the read address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            written_q_reg <= 1'b0;
            byp_hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                written_reg[wr_a] <= 1'b1;
            end
            if (rd_en)
            begin
                written_q_reg <= written_reg[rd_a];
                byp_hit_reg   <= wr.en && (wr_a == rd_a);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_clip_reg <= wr.clip;
        end
    end

    // Unwritten entries read as zero
    always_comb
    begin
        if (byp_hit_reg)
        begin
            rd_clip = byp_clip_reg;
        end
        else if (written_q_reg)
        begin
            rd_clip = acs_pkg::clip_t'(ram_q);
        end
        else
        begin
            rd_clip = '0;
        end
    end

endmodule

@@ rtl/acs_queue.sv @@
module acs_queue #(
    parameter int QUEUE_DEPTH = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             exec,
    input  acs_pkg::q_ctl_t                  ctl,
    input  acs_pkg::def_upd_t                upd,
    output acs_pkg::entry_t                  head,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
    output logic                             full
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    acs_pkg::entry_t entries_reg  [QUEUE_DEPTH];
    acs_pkg::entry_t entries_next [QUEUE_DEPTH];
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    // Shift on pop, write at the tail on push, refresh copied ranges on define
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (ctl.pop && (i + 1 < QUEUE_DEPTH))
            begin
                entries_next[i] = entries_reg[i + 1];
            end
            if (ctl.push && (CW'(i) == count_reg))
            begin
                entries_next[i] = ctl.entry;
            end
            if (upd.en && (entries_reg[i].index == upd.index))
            begin
                entries_next[i].first_frame = upd.clip.first_frame;
                entries_next[i].last_frame  = upd.clip.last_frame;
            end
        end
        count_next = count_reg;
        if (ctl.flush)
        begin
            count_next = '0;
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (ctl.push)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
        end
    end

    assign head  = entries_reg[0];
    assign count = count_reg;
    assign full  = (count_reg == CW'(QUEUE_DEPTH));

endmodule

@@ rtl/acs_player.sv @@
module acs_player #(
    parameter int QUEUE_DEPTH = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             exec,
    input  acs_pkg::item_t                   item,
    input  acs_pkg::clip_t                   rd_clip,
    input  acs_pkg::def_upd_t                upd,
    input  acs_pkg::entry_t                  head,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
    input  logic                             q_full,
    output acs_pkg::q_ctl_t                  q_ctl,
    output logic                             playing,
    output logic [4:0]                       current_index,
    output logic signed [31:0]               anim_time,
    output logic                             reached_end,
    output logic                             started,
    output logic                             accepted
);

    logic               valid_reg,    valid_next;
    logic [4:0]         clip_reg,     clip_next;
    logic signed [31:0] time_reg,     time_next;
    logic signed [15:0] speed_reg,    speed_next;
    logic               loop_reg,     loop_next;
    logic               end_reg,      end_next;
    logic               started_reg,  started_next;
    logic               accepted_reg, accepted_next;
    logic [15:0]        first_reg,    first_next;
    logic [15:0]        last_reg,     last_next;

    logic signed [15:0] actual;
    logic signed [32:0] prod;
    logic signed [24:0] delta;
    logic signed [33:0] sum;
    logic signed [33:0] t;
    logic signed [33:0] s;
    logic signed [33:0] e;
    logic signed [33:0] span;
    logic signed [33:0] tc;
    logic               beyond;
    logic               below;
    logic               q_busy;

    // Tick arithmetic: delta is speed times step, floored to Q16.8
    assign actual = (item.speed == 16'sd0) ? rd_clip.def_speed : item.speed;
    assign prod   = 33'(speed_reg) * 33'($signed({1'b0, item.step}));
    assign delta  = prod[32:8];
    assign sum    = 34'(time_reg) + 34'(delta);
    assign t      = 34'(acs_pkg::sat32(sum));
    assign s      = $signed({10'd0, first_reg, 8'd0});
    assign e      = $signed({10'd0, last_reg, 8'd0});
    assign span   = e - s;
    assign beyond = (t > e);
    assign below  = (t < s);
    assign q_busy = (q_count != '0);

    always_comb
    begin
        valid_next    = valid_reg;
        clip_next     = clip_reg;
        time_next     = time_reg;
        speed_next    = speed_reg;
        loop_next     = loop_reg;
        end_next      = end_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        started_next  = 1'b0;
        accepted_next = 1'b1;
        q_ctl         = '0;
        tc            = t;

        q_ctl.entry.index       = item.index;
        q_ctl.entry.loop        = item.loop;
        q_ctl.entry.speed       = actual;
        q_ctl.entry.first_frame = rd_clip.first_frame;
        q_ctl.entry.last_frame  = rd_clip.last_frame;

        unique case (item.action)
            acs_pkg::ACT_PLAY:
            begin
                // Restart at once and drop everything queued
                valid_next   = 1'b1;
                clip_next    = item.index;
                loop_next    = item.loop;
                speed_next   = actual;
                end_next     = 1'b0;
                first_next   = rd_clip.first_frame;
                last_next    = rd_clip.last_frame;
                time_next    = acs_pkg::start_time(rd_clip.first_frame,
                                                   rd_clip.last_frame, actual);
                q_ctl.flush  = 1'b1;
                started_next = 1'b1;
            end
            acs_pkg::ACT_ENQUEUE:
            begin
                if (!valid_reg)
                begin
                    // Idle: take the clip as current, keep the time
                    valid_next = 1'b1;
                    clip_next  = item.index;
                    loop_next  = item.loop;
                    speed_next = actual;
                    first_next = rd_clip.first_frame;
                    last_next  = rd_clip.last_frame;
                end
                else if (q_full)
                begin
                    accepted_next = 1'b0;
                end
                else
                begin
                    q_ctl.push = 1'b1;
                end
            end
            acs_pkg::ACT_TICK:
            begin
                if (valid_reg)
                begin
                    end_next = 1'b0;
                    if ((beyond || below) && (!loop_reg || q_busy))
                    begin
                        // Clamp to the clip range, then hand over to the queue head if one waits
                        if (below)
                        begin
                            tc = s;
                        end
                        if (tc > e)
                        begin
                            tc = e;
                        end
                        end_next  = 1'b1;
                        time_next = tc[31:0];
                        if (q_busy)
                        begin
                            clip_next    = head.index;
                            loop_next    = head.loop;
                            speed_next   = head.speed;
                            first_next   = head.first_frame;
                            last_next    = head.last_frame;
                            time_next    = acs_pkg::start_time(head.first_frame,
                                                               head.last_frame,
                                                               head.speed);
                            q_ctl.pop    = 1'b1;
                            started_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // Wrap a looping clip by one span
                        if (e == s)
                        begin
                            tc = e;
                        end
                        else if (beyond)
                        begin
                            tc           = t - span;
                            started_next = 1'b1;
                        end
                        else if (below)
                        begin
                            tc = t + span;
                        end
                        time_next = acs_pkg::sat32(tc);
                    end
                end
            end
            acs_pkg::ACT_DEFINE:
            begin
                // Keep the copy of the current clip's range in step with the table
                if (upd.en && (upd.index == clip_reg))
                begin
                    first_next = upd.clip.first_frame;
                    last_next  = upd.clip.last_frame;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            clip_reg     <= '0;
            time_reg     <= '0;
            speed_reg    <= '0;
            loop_reg     <= 1'b0;
            end_reg      <= 1'b0;
            first_reg    <= '0;
            last_reg     <= '0;
            started_reg  <= 1'b0;
            accepted_reg <= 1'b1;
        end
        else if (exec)
        begin
            valid_reg    <= valid_next;
            clip_reg     <= clip_next;
            time_reg     <= time_next;
            speed_reg    <= speed_next;
            loop_reg     <= loop_next;
            end_reg      <= end_next;
            first_reg    <= first_next;
            last_reg     <= last_next;
            started_reg  <= started_next;
            accepted_reg <= accepted_next;
        end
    end

    assign playing       = valid_reg;
    assign current_index = clip_reg;
    assign anim_time     = time_reg;
    assign reached_end   = end_reg;
    assign started       = started_reg;
    assign accepted      = accepted_reg;

endmodule

@@ rtl/animation_clip_sequencer.sv @@
// Animation clip sequencer.
// Requests enter on the in_valid / in_ready channel: play now, enqueue, tick
// or define a clip table entry. Each request yields one result on the
// out_valid / out_ready channel showing the playback state after it, plus
// the start-event and accepted flags for that request.
// The clip count register is written through cfg_valid / cfg_ready
// (always ready); write it only while no request is in flight.
// A request passes the input register, where the table is read, and then the
// result registers before its result is presented.
// Throughput: one request per cycle while results are taken; the clip table
// is read once per request through its single read port, in the cycle the
// request is taken. On a receiver stall the result holds, one more request
// enters the input register, and in_ready drops until the result is taken.
// Reset empties the queue, stops playback, zeroes the clip table (through
// per-entry written flags, no clearing pass) and sets the clip count to 32.
module animation_clip_sequencer #(
    parameter int QUEUE_DEPTH = 5,
    parameter int CLIP_SLOTS  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [5:0]                       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       action,
    input  logic [4:0]                       anim_index,
    input  logic                             loop_flag,
    input  logic signed [15:0]               speed,
    input  logic [15:0]                      time_step,
    input  logic [15:0]                      range_start,
    input  logic [15:0]                      range_end,
    input  logic signed [15:0]               default_speed,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             playing,
    output logic [4:0]                       current_index,
    output logic signed [31:0]               anim_time,
    output logic                             reached_end,
    output logic                             started,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] queued_count,
    output logic                             accepted
);

    localparam logic [5:0] NUM_ANIMS_RESET = 6'd32;

    logic [5:0]        num_anims_reg;
    logic              s1_valid_reg;
    acs_pkg::item_t    s1_item_reg;
    acs_pkg::item_t    s1_item_next;
    logic              out_valid_reg;
    logic              advance;
    logic              exec;
    logic              take;
    logic              idx_ok;
    logic              slot_ok;
    acs_pkg::clip_t    rd_clip;
    acs_pkg::def_upd_t upd;
    acs_pkg::q_ctl_t   q_ctl;
    acs_pkg::entry_t   q_head;
    logic              q_full;

    // Handshake: the input register moves on whenever the result is free
    assign advance   = !out_valid_reg || out_ready;
    assign exec      = s1_valid_reg && advance;
    assign in_ready  = !s1_valid_reg || advance;
    assign take      = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    // Map an out-of-range clip index to clip 0
    assign slot_ok = (32'(anim_index) < CLIP_SLOTS);
    assign idx_ok  = ({1'b0, anim_index} < num_anims_reg) && slot_ok;

    always_comb
    begin
        s1_item_next.action               = action;
        s1_item_next.index                = idx_ok ? anim_index : 5'd0;
        s1_item_next.raw_index            = anim_index;
        s1_item_next.def_ok               = slot_ok;
        s1_item_next.loop                 = loop_flag;
        s1_item_next.speed                = speed;
        s1_item_next.step                 = time_step;
        s1_item_next.def_clip.first_frame = range_start;
        s1_item_next.def_clip.last_frame  = range_end;
        s1_item_next.def_clip.def_speed   = default_speed;
    end

    // Table write when a define request with an index inside the table executes
    assign upd.en    = exec && (s1_item_reg.action == acs_pkg::ACT_DEFINE)
                       && s1_item_reg.def_ok;
    assign upd.index = s1_item_reg.raw_index;
    assign upd.clip  = s1_item_reg.def_clip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_anims_reg <= NUM_ANIMS_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                num_anims_reg <= cfg_data;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the request payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    acs_clip_table #(
        .CLIP_SLOTS (CLIP_SLOTS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (take),
        .rd_index (s1_item_next.index),
        .wr       (upd),
        .rd_clip  (rd_clip)
    );

    acs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .exec  (exec),
        .ctl   (q_ctl),
        .upd   (upd),
        .head  (q_head),
        .count (queued_count),
        .full  (q_full)
    );

    acs_player #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_player (
        .clk           (clk),
        .rst_n         (rst_n),
        .exec          (exec),
        .item          (s1_item_reg),
        .rd_clip       (rd_clip),
        .upd           (upd),
        .head          (q_head),
        .q_count       (queued_count),
        .q_full        (q_full),
        .q_ctl         (q_ctl),
        .playing       (playing),
        .current_index (current_index),
        .anim_time     (anim_time),
        .reached_end   (reached_end),
        .started       (started),
        .accepted      (accepted)
    );

endmodule
